>>> rtl/jtl_pkg.sv
// Shared types, byte codes and keyword helpers for the JSON token lexer.
package jtl_pkg;

  // Stream position counter width (16..64); start_pos carries the low 32 bits
  localparam int POS_BITS = 32;

  // Longest number token the limit register can ask for
  localparam logic [6:0] NUM_LIMIT = 7'd64;

  // Token queue between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  // Byte codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_E  = 8'h65;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_S  = 8'h73;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef enum logic [2:0] {
    MODE_BASE   = 3'd0,
    MODE_STRING = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_TRUE   = 3'd3,
    MODE_FALSE  = 3'd4,
    MODE_NULL   = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    KIND_NUMBER = 4'd0,
    KIND_STRING = 4'd1,
    KIND_TRUE   = 4'd2,
    KIND_FALSE  = 4'd3,
    KIND_NULL   = 4'd4,
    KIND_LBRACE = 4'd5,
    KIND_RBRACE = 4'd6,
    KIND_LBRACK = 4'd7,
    KIND_RBRACK = 4'd8,
    KIND_ERROR  = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_UNKNOWN  = 3'd1,
    ERR_KEYWORD  = 3'd2,
    ERR_FOLLOW   = 3'd3,
    ERR_TOO_LONG = 3'd4,
    ERR_ESCAPE   = 3'd5
  } err_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] len;
    err_t        err;
  } tok_t;

  // One queue entry holds every token of one byte (one or two)
  typedef struct packed {
    logic two;
    tok_t tok0;
    tok_t tok1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_skip(input logic [7:0] b);
    return (b == CH_COLON) || (b == CH_COMMA) || (b == CH_SPACE) ||
           ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_num(input logic [7:0] b);
    return ((b >= CH_ZERO) && (b <= CH_NINE)) || (b == CH_MINUS) ||
           (b == CH_DOT) || (b == CH_PLUS) || (b == CH_LOW_E) || (b == CH_UP_E);
  endfunction

  // Low 32 bits of a stream position, zero-extended for narrow counters
  function automatic logic [31:0] pos_lo32(input logic [POS_BITS-1:0] p);
    logic [63:0] w;
    w = 64'(p);
    return w[31:0];
  endfunction

  function automatic logic [2:0] kw_len(input mode_t m);
    logic [2:0] n;
    unique case (m)
      MODE_FALSE: n = 3'd5;
      default:    n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic kind_t kw_kind(input mode_t m);
    kind_t k;
    unique case (m)
      MODE_TRUE:  k = KIND_TRUE;
      MODE_FALSE: k = KIND_FALSE;
      default:    k = KIND_NULL;
    endcase
    return k;
  endfunction

  // Expected letter at index i of the keyword being matched
  function automatic logic [7:0] kw_char(input mode_t m, input logic [2:0] i);
    logic [7:0] c;
    c = CH_NUL;
    unique case (m)
      MODE_TRUE: begin
        case (i)
          3'd0:    c = CH_LOW_T;
          3'd1:    c = CH_LOW_R;
          3'd2:    c = CH_LOW_U;
          3'd3:    c = CH_LOW_E;
          default: c = CH_NUL;
        endcase
      end
      MODE_FALSE: begin
        case (i)
          3'd0:    c = CH_LOW_F;
          3'd1:    c = CH_LOW_A;
          3'd2:    c = CH_LOW_L;
          3'd3:    c = CH_LOW_S;
          3'd4:    c = CH_LOW_E;
          default: c = CH_NUL;
        endcase
      end
      default: begin
        case (i)
          3'd0:    c = CH_LOW_N;
          3'd1:    c = CH_LOW_U;
          3'd2:    c = CH_LOW_L;
          3'd3:    c = CH_LOW_L;
          default: c = CH_NUL;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

>>> rtl/json_token_lexer_core.sv
// Top level of the streaming JSON token lexer.
//
// Input channel: one text byte per beat on in_data_byte, in_valid/in_stall.
// Output channel: one token per beat (kind, start position, length, error
// code, last_of_run), out_valid/out_stall. A byte yields zero, one or two
// tokens; last_of_run marks the final token of a byte.
// Configuration: cfg_wr_en writes cfg_wr_data into the number length limit
// (reset 64); write only while no tokens are in flight.
// A token passes from its byte through the token queue and then the output
// register before it appears on the output; the second token of a byte
// follows it through the output register. Throughput: one byte per cycle
// while the queue is not full; a byte with two tokens gives two output beats.
// The front keeps all lexing state and pushes each byte's tokens into a
// four-entry queue; the back drains it one token per cycle into the output
// register while out_stall does not hold the output. in_stall rises only
// when that queue is full, so a stalled receiver holds the output beat and
// lets up to four more token-producing bytes in before the input stalls.
// Reset (rst_n low, synchronous) clears lexing mode, positions, counts, the
// error halt and the queue. After an error token the lexer takes and drops
// bytes until the next reset.
module json_token_lexer_core import jtl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [31:0] out_start_pos,
  output logic [31:0] out_token_length,
  output logic [2:0]  out_error_code,
  output logic        out_last_of_run
);

  q_stat_t q_stat;
  logic    push;
  entry_t  push_entry;
  logic    pop;
  entry_t  head;

  jtl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  jtl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  jtl_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_start_pos    (out_start_pos),
    .out_token_length (out_token_length),
    .out_error_code   (out_error_code),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

>>> rtl/jtl_front.sv
// Lexer front: takes bytes, tracks lexing mode and builds the tokens of each byte.
module jtl_front import jtl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  q_stat_t    q_stat,
  output logic       push,
  output entry_t     push_entry
);

  mode_t                mode_r,   mode_nxt;
  logic [2:0]           kw_idx_r, kw_idx_nxt;
  logic [POS_BITS-1:0]  pos_r,    pos_nxt;
  logic [POS_BITS-1:0]  start_r,  start_nxt;
  logic [31:0]          cnt_r,    cnt_nxt;
  logic                 halted_r, halted_nxt;
  logic [6:0]           max_len_r;

  logic       accept;
  logic       fire;
  logic [7:0] b;
  logic [6:0] lim;
  logic [31:0] cnt_inc;

  // byte classes
  logic  b_skip, b_num, b_brk, b_quote, b_kw, b_follow;
  kind_t b_brk_kind;
  mode_t b_kw_mode;

  // decode results
  logic close_c;
  logic relex_c;
  err_t err_c;

  tok_t close_tok, act_tok;
  logic act_vld;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign fire     = accept && !halted_r;
  assign b        = in_data_byte;
  assign lim      = (max_len_r > NUM_LIMIT) ? NUM_LIMIT : max_len_r;
  assign cnt_inc  = cnt_r + 32'd1;

  // byte classification
  always_comb begin
    b_brk      = 1'b1;
    b_brk_kind = KIND_LBRACE;
    unique case (b)
      CH_LBRACE: b_brk_kind = KIND_LBRACE;
      CH_RBRACE: b_brk_kind = KIND_RBRACE;
      CH_LBRACK: b_brk_kind = KIND_LBRACK;
      CH_RBRACK: b_brk_kind = KIND_RBRACK;
      default:   b_brk      = 1'b0;
    endcase
    b_kw      = 1'b1;
    b_kw_mode = MODE_TRUE;
    unique case (b)
      CH_LOW_T: b_kw_mode = MODE_TRUE;
      CH_LOW_F: b_kw_mode = MODE_FALSE;
      CH_LOW_N: b_kw_mode = MODE_NULL;
      default:  b_kw      = 1'b0;
    endcase
    b_skip   = is_skip(b);
    b_num    = is_num(b);
    b_quote  = (b == CH_QUOTE);
    b_follow = b_skip || (b == CH_RBRACK) || (b == CH_RBRACE);
  end

  // decode: does this byte close a token, re-lex in base mode, or fail
  always_comb begin
    close_c = 1'b0;
    relex_c = 1'b0;
    err_c   = ERR_NONE;
    unique case (mode_r) inside
      MODE_STRING: begin
        if (b_quote) close_c = 1'b1;
        else if (b == CH_BSLASH) err_c = ERR_ESCAPE;
      end
      MODE_NUMBER: begin
        if (b_num) begin
          if (cnt_inc > 32'(lim)) err_c = ERR_TOO_LONG;
        end else begin
          close_c = 1'b1;
          relex_c = 1'b1;
        end
      end
      MODE_TRUE, MODE_FALSE, MODE_NULL: begin
        if (kw_idx_r < kw_len(mode_r)) begin
          if (b != kw_char(mode_r, kw_idx_r)) err_c = ERR_KEYWORD;
        end else if (b_follow) begin
          close_c = 1'b1;
          relex_c = 1'b1;
        end else begin
          err_c = ERR_FOLLOW;
        end
      end
      default: relex_c = 1'b1;
    endcase
    // base-mode errors
    if (relex_c && !(b_skip || b_brk || b_quote || b_kw)) begin
      if (b_num) begin
        if (lim == 7'd0) err_c = ERR_TOO_LONG;
      end else begin
        err_c = ERR_UNKNOWN;
      end
    end
  end

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    kw_idx_nxt = kw_idx_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    cnt_nxt    = cnt_r;
    halted_nxt = halted_r;
    if (fire) begin
      if (err_c != ERR_NONE) begin
        halted_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + 1'b1;
        unique case (mode_r) inside
          MODE_STRING: begin
            if (close_c) mode_nxt = MODE_BASE;
            else if (cnt_r != '1) cnt_nxt = cnt_inc;
          end
          MODE_NUMBER: begin
            if (!relex_c) cnt_nxt = cnt_inc;
          end
          MODE_TRUE, MODE_FALSE, MODE_NULL: begin
            if (!relex_c) kw_idx_nxt = kw_idx_r + 3'd1;
          end
          default: ;
        endcase
        if (relex_c) begin
          mode_nxt = MODE_BASE;
          if (b_quote) begin
            mode_nxt  = MODE_STRING;
            start_nxt = pos_r + 1'b1;
            cnt_nxt   = 32'd0;
          end else if (b_kw) begin
            mode_nxt   = b_kw_mode;
            kw_idx_nxt = 3'd1;
            start_nxt  = pos_r;
          end else if (b_num && !b_skip && !b_brk) begin
            mode_nxt  = MODE_NUMBER;
            start_nxt = pos_r;
            cnt_nxt   = 32'd1;
          end
        end
      end
    end
  end

  // token outputs
  always_comb begin
    close_tok       = '0;
    close_tok.start = pos_lo32(start_r);
    close_tok.err   = ERR_NONE;
    unique case (mode_r) inside
      MODE_STRING: begin
        close_tok.kind = KIND_STRING;
        close_tok.len  = cnt_r;
      end
      MODE_TRUE, MODE_FALSE, MODE_NULL: begin
        close_tok.kind = kw_kind(mode_r);
        close_tok.len  = 32'(kw_len(mode_r));
      end
      default: begin
        close_tok.kind = KIND_NUMBER;
        close_tok.len  = cnt_r;
      end
    endcase

    act_tok       = '0;
    act_tok.start = pos_lo32(pos_r);
    act_vld       = 1'b0;
    if (err_c != ERR_NONE) begin
      act_vld      = 1'b1;
      act_tok.kind = KIND_ERROR;
      act_tok.len  = 32'd0;
      act_tok.err  = err_c;
    end else begin
      act_vld      = relex_c && b_brk;
      act_tok.kind = b_brk_kind;
      act_tok.len  = 32'd1;
      act_tok.err  = ERR_NONE;
    end

    push            = fire && (close_c || act_vld);
    push_entry.two  = close_c && act_vld;
    push_entry.tok0 = close_c ? close_tok : act_tok;
    push_entry.tok1 = act_tok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_BASE;
      kw_idx_r  <= 3'd0;
      pos_r     <= '0;
      start_r   <= '0;
      cnt_r     <= 32'd0;
      halted_r  <= 1'b0;
      max_len_r <= NUM_LIMIT;
    end else begin
      mode_r   <= mode_nxt;
      kw_idx_r <= kw_idx_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      cnt_r    <= cnt_nxt;
      halted_r <= halted_nxt;
      if (cfg_wr_en) max_len_r <= cfg_wr_data;
    end
  end

  // a halted lexer produces nothing and its position stays put
  a_halt_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |-> !push) else $error("token pushed while halted");
  a_halt_pos: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> $stable(pos_r)) else $error("position moved while halted");

endmodule

>>> rtl/jtl_queue.sv
// Short token queue between the lexer front and the output back end.
module jtl_queue import jtl_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  head,
  output q_stat_t q_stat
);

  entry_t               mem_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_BITS:0]   cnt_r,    cnt_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == (QPTR_BITS+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty) else $error("queue underflow");

endmodule

>>> rtl/jtl_back.sv
// Output back end: splits queue entries into single token beats behind an output register.
module jtl_back import jtl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     q_stat,
  input  entry_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [31:0] out_start_pos,
  output logic [31:0] out_token_length,
  output logic [2:0]  out_error_code,
  output logic        out_last_of_run
);

  logic out_valid_r, out_valid_nxt;
  logic sub_r,       sub_nxt;
  tok_t out_tok_r;
  logic out_last_r;

  logic load;
  logic last_c;
  tok_t tok_c;

  // pick the next token of the head entry when the output register frees up
  always_comb begin
    load          = !q_stat.empty && (!out_valid_r || !out_stall);
    last_c        = !head.two || sub_r;
    tok_c         = sub_r ? head.tok1 : head.tok0;
    pop           = load && last_c;
    sub_nxt       = load ? !last_c : sub_r;
    out_valid_nxt = load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sub_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_tok_r  <= tok_c;
      out_last_r <= last_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_token_kind   = out_tok_r.kind;
  assign out_start_pos    = out_tok_r.start;
  assign out_token_length = out_tok_r.len;
  assign out_error_code   = out_tok_r.err;
  assign out_last_of_run  = out_last_r;

  // second half of a pair only while its entry is still at the head
  a_sub_pair: assert property (@(posedge clk) disable iff (!rst_n)
    sub_r |-> (!q_stat.empty && head.two)) else $error("second token without pair");

endmodule

>>> sim/tb_json_token_lexer_core.sv
// Self-checking testbench for the streaming JSON token lexer core.
module tb_json_token_lexer_core;
  import jtl_pkg::*;

  // Whitespace bytes the package does not name
  localparam logic [7:0] LF_BYTE = 8'h0A;
  localparam logic [7:0] VT_BYTE = 8'h0B;
  localparam logic [7:0] FF_BYTE = 8'h0C;

  localparam int PHASE_BYTES = 130;

  // Ways the run ends: one fault halts the lexer for good
  typedef enum int {
    BAD_UNKNOWN,
    BAD_KEYWORD,
    BAD_FOLLOW,
    BAD_LONG,
    BAD_LONG_ZERO,
    BAD_ESCAPE,
    BAD_AFTER_NUMBER
  } fault_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] len;
    err_t        err;
    logic        last;
  } token_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_token_kind;
  logic [31:0] out_start_pos;
  logic [31:0] out_token_length;
  logic [2:0]  out_error_code;
  logic        out_last_of_run;

  json_token_lexer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_token_kind   (out_token_kind),
    .out_start_pos    (out_start_pos),
    .out_token_length (out_token_length),
    .out_error_code   (out_error_code),
    .out_last_of_run  (out_last_of_run)
  );

  // Stimulus and expected tokens
  logic [7:0] byte_feed[$];
  token_rec_t tokens_due[$];
  token_rec_t byte_toks[$];

  // Lexer state as the testbench tracks it
  mode_t               scan_mode;
  logic [2:0]          kw_pos;
  logic [POS_BITS-1:0] stream_pos;
  logic [POS_BITS-1:0] tok_first;
  logic [31:0]         tok_bytes;
  bit                  halted;
  logic [6:0]          num_limit;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int mismatches = 0;
  int bytes_taken = 0;
  int tokens_seen = 0;
  token_rec_t want;

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- byte classes

  function automatic bit skip_byte(input logic [7:0] b);
    case (b)
      CH_COLON, CH_COMMA, CH_SPACE, CH_TAB, LF_BYTE, VT_BYTE, FF_BYTE, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit number_byte(input logic [7:0] b);
    if (b >= CH_ZERO && b <= CH_NINE) return 1'b1;
    case (b)
      CH_MINUS, CH_PLUS, CH_DOT, CH_LOW_E, CH_UP_E: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Anything base mode can start a token with or skip
  function automatic bit base_ok(input logic [7:0] b);
    case (b)
      CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_QUOTE,
      CH_LOW_T, CH_LOW_F, CH_LOW_N: return 1'b1;
      default: return skip_byte(b) || number_byte(b);
    endcase
  endfunction

  function automatic string kw_word(input mode_t m);
    case (m)
      MODE_TRUE:  return "true";
      MODE_FALSE: return "false";
      default:    return "null";
    endcase
  endfunction

  // ---------------------------------------------------------------- prediction

  task automatic push_token(input kind_t k, input logic [POS_BITS-1:0] s,
                            input logic [31:0] n, input err_t e);
    token_rec_t t;
    t.kind  = k;
    t.start = 32'(s);
    t.len   = n;
    t.err   = e;
    t.last  = 1'b0;
    byte_toks.push_back(t);
  endtask

  task automatic halt_with(input err_t e);
    push_token(KIND_ERROR, stream_pos, 32'd0, e);
    halted = 1'b1;
  endtask

  function automatic bit over_limit();
    logic [6:0] lim;
    lim = (num_limit > NUM_LIMIT) ? NUM_LIMIT : num_limit;
    return tok_bytes > 32'(lim);
  endfunction

  task automatic lex_from_base(input logic [7:0] b);
    scan_mode = MODE_BASE;
    if (skip_byte(b)) return;
    case (b)
      CH_LBRACE: push_token(KIND_LBRACE, stream_pos, 32'd1, ERR_NONE);
      CH_RBRACE: push_token(KIND_RBRACE, stream_pos, 32'd1, ERR_NONE);
      CH_LBRACK: push_token(KIND_LBRACK, stream_pos, 32'd1, ERR_NONE);
      CH_RBRACK: push_token(KIND_RBRACK, stream_pos, 32'd1, ERR_NONE);
      CH_QUOTE: begin
        // string position starts past the quote
        scan_mode = MODE_STRING;
        tok_first = stream_pos + 1'b1;
        tok_bytes = '0;
      end
      CH_LOW_T, CH_LOW_F, CH_LOW_N: begin
        scan_mode = (b == CH_LOW_T) ? MODE_TRUE : (b == CH_LOW_F) ? MODE_FALSE : MODE_NULL;
        kw_pos    = 3'd1;
        tok_first = stream_pos;
      end
      default: begin
        if (number_byte(b)) begin
          tok_first = stream_pos;
          tok_bytes = 32'd1;
          if (over_limit()) halt_with(ERR_TOO_LONG);
          else scan_mode = MODE_NUMBER;
        end else begin
          halt_with(ERR_UNKNOWN);
        end
      end
    endcase
  endtask

  // Tokens caused by one accepted byte, appended to tokens_due
  task automatic lex_byte(input logic [7:0] b);
    string      word;
    kind_t      kw_kind_v;
    token_rec_t t;
    byte_toks.delete();
    if (halted) return;
    case (scan_mode)
      MODE_STRING: begin
        if (b == CH_QUOTE) begin
          push_token(KIND_STRING, tok_first, tok_bytes, ERR_NONE);
          scan_mode = MODE_BASE;
        end else if (b == CH_BSLASH) begin
          halt_with(ERR_ESCAPE);
        end else if (tok_bytes != '1) begin
          tok_bytes++;
        end
      end
      MODE_NUMBER: begin
        if (number_byte(b)) begin
          tok_bytes++;
          if (over_limit()) halt_with(ERR_TOO_LONG);
        end else begin
          // closing byte gives the number, then is lexed itself
          push_token(KIND_NUMBER, tok_first, tok_bytes, ERR_NONE);
          lex_from_base(b);
        end
      end
      MODE_TRUE, MODE_FALSE, MODE_NULL: begin
        word = kw_word(scan_mode);
        case (scan_mode)
          MODE_TRUE:  kw_kind_v = KIND_TRUE;
          MODE_FALSE: kw_kind_v = KIND_FALSE;
          default:    kw_kind_v = KIND_NULL;
        endcase
        if (kw_pos < word.len()) begin
          if (b != word[kw_pos]) halt_with(ERR_KEYWORD);
          else kw_pos++;
        end else if (skip_byte(b) || b == CH_RBRACK || b == CH_RBRACE) begin
          push_token(kw_kind_v, tok_first, 32'(word.len()), ERR_NONE);
          lex_from_base(b);
        end else begin
          halt_with(ERR_FOLLOW);
        end
      end
      default: lex_from_base(b);
    endcase
    if (!halted) stream_pos++;
    if (byte_toks.size() != 0) begin
      t = byte_toks.pop_back();
      t.last = 1'b1;
      byte_toks.push_back(t);
    end
    foreach (byte_toks[i]) tokens_due.push_back(byte_toks[i]);
  endtask

  // ---------------------------------------------------------------- byte source

  // A beat is taken when valid is high and stall low; the next byte goes out
  // only once the current one is gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        lex_byte(in_data_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (byte_feed.size() == 0) begin
          in_valid <= 1'b0;
        end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else begin
          in_valid     <= 1'b1;
          in_data_byte <= byte_feed.pop_front();
        end
      end
    end
  end

  // ---------------------------------------------------------------- token sink

  function automatic int field_bad(input string name, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (tokens_due.size() == 0) begin
          $error("token with none expected: kind %0d start %0d length %0d",
                 out_token_kind, out_start_pos, out_token_length);
          mismatches++;
        end else begin
          want = tokens_due.pop_front();
          tokens_seen++;
          mismatches += field_bad("token_kind", 32'(want.kind), 32'(out_token_kind));
          mismatches += field_bad("start_pos", want.start, out_start_pos);
          mismatches += field_bad("token_length", want.len, out_token_length);
          mismatches += field_bad("error_code", 32'(want.err), 32'(out_error_code));
          mismatches += field_bad("last_of_run", 32'(want.last), 32'(out_last_of_run));
        end
      end
      // random stall bursts
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        recv_gap = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- text builders

  function automatic logic [7:0] pick_skip();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return CH_COLON;
    if (r == 1) return CH_COMMA;
    if (r == 2) return CH_SPACE;
    return CH_TAB + 8'(r - 3);
  endfunction

  function automatic logic [7:0] pick_num_char();
    string s;
    s = "0123456789+-.eE";
    return s[$urandom_range(0, 14)];
  endfunction

  function automatic string pick_word();
    case ($urandom_range(0, 2))
      0:       return kw_word(MODE_TRUE);
      1:       return kw_word(MODE_FALSE);
      default: return kw_word(MODE_NULL);
    endcase
  endfunction

  function automatic logic [7:0] pick_unknown();
    logic [7:0] b;
    do b = $urandom_range(0, 255); while (base_ok(b));
    return b;
  endfunction

  function automatic int limit_now();
    return (num_limit > NUM_LIMIT) ? int'(NUM_LIMIT) : int'(num_limit);
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_feed.push_back(s[i]);
  endtask

  // String body never holds a quote or a backslash
  task automatic gen_string_body(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = $urandom_range(0, 255); while (b == CH_QUOTE || b == CH_BSLASH);
      byte_feed.push_back(b);
    end
  endtask

  task automatic gen_number(input int n);
    for (int i = 0; i < n; i++) byte_feed.push_back(pick_num_char());
  endtask

  // Well-formed token soup; numbers and keywords are always closed properly
  task automatic gen_tokens(input int nbytes);
    int goal;
    int tail;
    int r;
    int lim;
    goal = byte_feed.size() + nbytes;
    tail = 0;
    lim  = limit_now();
    while (byte_feed.size() < goal) begin
      if (tail == 2) begin
        // only a separator or a closing bracket may follow a keyword
        r = $urandom_range(0, 3);
        byte_feed.push_back(r == 0 ? CH_RBRACK : r == 1 ? CH_RBRACE : pick_skip());
        tail = 0;
      end else begin
        r = $urandom_range(0, 9);
        // a number right after a number would merge into one
        if (tail == 1 && r >= 7) r = $urandom_range(0, 6);
        tail = 0;
        if (r <= 1) begin
          byte_feed.push_back(CH_QUOTE);
          gen_string_body(($urandom_range(0, 9) == 0) ? $urandom_range(0, 60)
                                                      : $urandom_range(0, 8));
          byte_feed.push_back(CH_QUOTE);
        end else if (r <= 3) begin
          case ($urandom_range(0, 3))
            0:       byte_feed.push_back(CH_LBRACE);
            1:       byte_feed.push_back(CH_RBRACE);
            2:       byte_feed.push_back(CH_LBRACK);
            default: byte_feed.push_back(CH_RBRACK);
          endcase
        end else if (r == 4) begin
          byte_feed.push_back(pick_skip());
        end else if (r <= 6) begin
          push_text(pick_word());
          tail = 2;
        end else begin
          gen_number(($urandom_range(0, 7) == 0) ? lim
                                                 : $urandom_range(1, (lim < 6) ? lim : 6));
          tail = 1;
        end
      end
    end
    if (tail != 0) byte_feed.push_back(CH_SPACE);
  endtask

  // ---------------------------------------------------------------- sequencing

  task automatic set_number_limit(input logic [6:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    num_limit = v;
  endtask

  // Hold off until every byte is taken and every token has arrived
  task automatic wait_idle();
    @(negedge clk);
    while (byte_feed.size() != 0 || in_valid || tokens_due.size() != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    logic [6:0] limits[6];
    fault_t     fault;
    string      word;
    logic [7:0] b;
    int         i;

    scan_mode  = MODE_BASE;
    kw_pos     = '0;
    stream_pos = '0;
    tok_first  = '0;
    tok_bytes  = '0;
    halted     = 1'b0;
    num_limit  = NUM_LIMIT;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every non-error token kind, two-token bytes, empty string, byte extremes
    @(negedge clk);
    send_idle_pct = 20;
    recv_idle_pct = 20;
    push_text("[null,\"");
    byte_feed.push_back(8'h00);
    byte_feed.push_back(8'hFF);
    push_text("\"{true}-9.E+e0]false\t\"\"\n");
    wait_idle();

    // Random phases over several limit settings, extremes included
    limits[0] = 7'd1;
    limits[1] = 7'd127;
    limits[2] = 7'($urandom_range(2, 63));
    limits[3] = NUM_LIMIT;
    limits[4] = 7'($urandom_range(65, 126));
    limits[5] = 7'($urandom_range(1, 64));
    for (int p = 0; p < 6; p++) begin
      set_number_limit(limits[p]);
      @(negedge clk);
      // one quiet middle phase, and no idling at the end
      if (p == 2 || p == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = $urandom_range(5, 35);
        recv_idle_pct = $urandom_range(5, 35);
      end
      gen_tokens(PHASE_BYTES);
      wait_idle();
    end

    // Close with one fault, then bytes the halted lexer must drop
    fault = fault_t'($urandom_range(0, 6));
    if (fault == BAD_LONG_ZERO) set_number_limit(7'd0);
    @(negedge clk);
    gen_tokens(20);
    case (fault)
      BAD_UNKNOWN: byte_feed.push_back(pick_unknown());
      BAD_KEYWORD: begin
        word = pick_word();
        i = $urandom_range(1, word.len() - 1);
        push_text(word.substr(0, i - 1));
        do b = $urandom_range(0, 255); while (b == word[i]);
        byte_feed.push_back(b);
      end
      BAD_FOLLOW: begin
        push_text(pick_word());
        do b = $urandom_range(0, 255);
        while (skip_byte(b) || b == CH_RBRACK || b == CH_RBRACE);
        byte_feed.push_back(b);
      end
      BAD_LONG:      gen_number(limit_now() + 1);
      BAD_LONG_ZERO: byte_feed.push_back(pick_num_char());
      BAD_ESCAPE: begin
        byte_feed.push_back(CH_QUOTE);
        gen_string_body($urandom_range(0, 6));
        byte_feed.push_back(CH_BSLASH);
      end
      default: begin
        gen_number($urandom_range(1, limit_now()));
        byte_feed.push_back(pick_unknown());
      end
    endcase
    for (int k = 0; k < 12; k++) byte_feed.push_back($urandom_range(0, 255));
    wait_idle();
    repeat (10) @(posedge clk);

    $display("Lexed %0d bytes into %0d checked tokens across seven number-limit settings.",
             bytes_taken, tokens_seen);
    $display("Run closed on fault %s followed by bytes into the halted lexer.", fault.name());
    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
rtl/jtl_pkg.sv
rtl/jtl_front.sv
rtl/jtl_queue.sv
rtl/jtl_back.sv
rtl/json_token_lexer_core.sv
sim/tb_json_token_lexer_core.sv
